### rtl/core/fmp_pkg.sv
// ---------------------------------------------------------------------------
// fmp_pkg
// Shared types and constants of the framed message parser: register
// indexes and reset values, the configuration record and the fixed field widths.
// ---------------------------------------------------------------------------
package fmp_pkg;

    // Fixed field widths.
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int SRC_CODES = 5;

    // Framing bytes (header, checksum and end) that count against the message capacity.
    localparam int LEN_OVERHEAD = 8;

    // Seed of the payload checksum.
    localparam logic [BYTE_W-1:0] SUM_SEED = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_A    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_B    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_C    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_D    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_E    = 8'd7;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] RST_START_BYTE  = 8'd2;
    localparam logic [BYTE_W-1:0] RST_END_BYTE    = 8'd3;
    localparam logic [BYTE_W-1:0] RST_OWN_ADDRESS = 8'd0;
    localparam logic [BYTE_W-1:0] RST_SOURCE_A    = 8'd1;
    localparam logic [BYTE_W-1:0] RST_SOURCE_B    = 8'd4;
    localparam logic [BYTE_W-1:0] RST_SOURCE_C    = 8'd5;
    localparam logic [BYTE_W-1:0] RST_SOURCE_D    = 8'd6;
    localparam logic [BYTE_W-1:0] RST_SOURCE_E    = 8'd7;

    // Current configuration as seen by the parser.
    typedef struct packed {
        logic [BYTE_W-1:0]                  start_byte;
        logic [BYTE_W-1:0]                  end_byte;
        logic [BYTE_W-1:0]                  own_address;
        logic [SRC_CODES-1:0][BYTE_W-1:0]   source_code;
    } t_cfg;

endpackage

### rtl/core/fmp_ifs.sv
// ---------------------------------------------------------------------------
// fmp_ifs
// Channel interfaces of the framed message parser: received bytes,
// parse results and configuration writes.
// ---------------------------------------------------------------------------

// Received byte channel.
interface fmp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Parse result channel.
interface fmp_res_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_ok;
    logic       frame_error;
    logic [7:0] source_id;
    logic [7:0] msg_count;

    modport source (output valid, output payload_valid, output payload_byte,
                    output payload_index, output frame_ok, output frame_error,
                    output source_id, output msg_count, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input payload_index, input frame_ok, input frame_error,
                    input source_id, input msg_count, output ready);
endinterface

// Configuration write channel.
interface fmp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_index;
    logic [7:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### rtl/core/fmp_cfg_regs.sv
// ---------------------------------------------------------------------------
// fmp_cfg_regs
// Configuration register file: decodes writes by register index and
// presents the current settings as one record.
// ---------------------------------------------------------------------------
module fmp_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fmp_cfg_if.sink       i_cfg,
    output fmp_pkg::t_cfg o_cfg
);
    import fmp_pkg::*;

    t_cfg r_cfg;
    logic wr_fire;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign wr_fire     = i_cfg.valid;

    // Register file; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte     <= RST_START_BYTE;
            r_cfg.end_byte       <= RST_END_BYTE;
            r_cfg.own_address    <= RST_OWN_ADDRESS;
            r_cfg.source_code[0] <= RST_SOURCE_A;
            r_cfg.source_code[1] <= RST_SOURCE_B;
            r_cfg.source_code[2] <= RST_SOURCE_C;
            r_cfg.source_code[3] <= RST_SOURCE_D;
            r_cfg.source_code[4] <= RST_SOURCE_E;
        end else if (wr_fire) begin
            unique case (i_cfg.reg_index)
                REG_START_BYTE:  r_cfg.start_byte     <= i_cfg.wr_data;
                REG_END_BYTE:    r_cfg.end_byte       <= i_cfg.wr_data;
                REG_OWN_ADDRESS: r_cfg.own_address    <= i_cfg.wr_data;
                REG_SOURCE_A:    r_cfg.source_code[0] <= i_cfg.wr_data;
                REG_SOURCE_B:    r_cfg.source_code[1] <= i_cfg.wr_data;
                REG_SOURCE_C:    r_cfg.source_code[2] <= i_cfg.wr_data;
                REG_SOURCE_D:    r_cfg.source_code[3] <= i_cfg.wr_data;
                REG_SOURCE_E:    r_cfg.source_code[4] <= i_cfg.wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/framed_message_parser.sv
// ---------------------------------------------------------------------------
// framed_message_parser
// Parses a byte stream of start, destination, source, count, 16-bit length,
// payload, checksum and end bytes, reporting each payload byte and the
// frame outcome with one result per received byte.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Transfer carries
//  -------  ---  -------------------------------------------------------
//  i_rx     in   rx_byte
//  o_res    out  payload_valid/byte/index, frame_ok, frame_error,
//                source_id, msg_count
//  i_cfg    in   reg_index, wr_data (always ready)
//
// Each received byte yields its result in the cycle after its transfer; a new
// byte is taken every cycle as long as the result register is empty or
// being drained in the same cycle. The result register is the only stage,
// so a stalled o_res holds i_rx after one byte. Reset is synchronous and
// returns the parser to hunting with the default register values.
// ---------------------------------------------------------------------------
module framed_message_parser #(
    parameter int MAX_MESSAGE = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fmp_cfg_if.sink   i_cfg,
    fmp_rx_if.sink    i_rx,
    fmp_res_if.source o_res
);
    import fmp_pkg::*;

    localparam int IDX_W = $clog2(MAX_MESSAGE + 1);
    localparam int CMP_W = (IDX_W + 1 > LEN_W + 1) ? IDX_W + 1 : LEN_W + 1;
    localparam logic [CMP_W-1:0] LEN_LIMIT = CMP_W'(MAX_MESSAGE - LEN_OVERHEAD);
    localparam logic [CMP_W-1:0] MSG_LIMIT = CMP_W'(MAX_MESSAGE);

    typedef enum logic [3:0] {
        PH_HUNT, PH_DEST, PH_SRC, PH_COUNT, PH_LEN_HI,
        PH_LEN_LO, PH_DATA, PH_SUM, PH_END
    } t_phase;

    t_cfg cfg;

    t_phase             r_phase,  n_phase;
    logic [IDX_W-1:0]   r_idx,    n_idx;
    logic [LEN_W-1:0]   r_len,    n_len;
    logic [BYTE_W-1:0]  r_sum,    n_sum;
    logic               r_zero,   n_zero;
    logic [BYTE_W-1:0]  r_src,    n_src;
    logic [BYTE_W-1:0]  r_cnt,    n_cnt;

    logic               r_out_valid;
    logic               r_pv,  n_pv;
    logic [BYTE_W-1:0]  r_pb,  n_pb;
    logic [BYTE_W-1:0]  r_pi,  n_pi;
    logic               r_ok,  n_ok;
    logic               r_err, n_err;

    logic [BYTE_W-1:0]  rx;
    logic               rx_fire;
    logic               src_hit;
    logic [IDX_W:0]     idx_inc;
    logic [IDX_W+7:0]   idx_ext;
    logic [LEN_W-1:0]   len_full;
    logic               zero_now;

    // Configuration registers.
    fmp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // A byte moves in when the result register is free or draining.
    assign rx             = i_rx.rx_byte;
    assign i_rx.ready     = !r_out_valid || o_res.ready;
    assign rx_fire        = i_rx.valid && i_rx.ready;

    // Source check against the five allowed codes.
    always_comb begin
        src_hit = 1'b0;
        for (int k = 0; k < SRC_CODES; k++) begin
            if (rx == cfg.source_code[k]) begin
                src_hit = 1'b1;
            end
        end
    end

    assign idx_inc  = {1'b0, r_idx} + 1'b1;
    assign idx_ext  = {8'd0, r_idx};
    assign len_full = {r_len[LEN_W-1:BYTE_W], rx};
    assign zero_now = r_zero || (rx == '0);

    // Next state and result for the byte on i_rx.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_len   = r_len;
        n_sum   = r_sum;
        n_zero  = r_zero;
        n_src   = r_src;
        n_cnt   = r_cnt;
        n_pv    = 1'b0;
        n_pb    = '0;
        n_pi    = '0;
        n_ok    = 1'b0;
        n_err   = 1'b0;
        unique case (r_phase)
            PH_HUNT: begin
                n_idx  = '0;
                n_sum  = SUM_SEED;
                n_zero = 1'b0;
                n_len  = '0;
                if (rx == cfg.start_byte) begin
                    n_phase = PH_DEST;
                end
            end
            PH_DEST: begin
                n_phase = (rx == cfg.own_address) ? PH_SRC : PH_HUNT;
            end
            PH_SRC: begin
                if (src_hit) begin
                    n_src   = rx;
                    n_phase = PH_COUNT;
                end else begin
                    n_err   = 1'b1;
                    n_phase = PH_HUNT;
                end
            end
            PH_COUNT: begin
                n_cnt   = rx;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = {rx, 8'd0};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len = len_full;
                if (CMP_W'(len_full) > LEN_LIMIT) begin
                    n_err   = 1'b1;
                    n_phase = PH_HUNT;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                // End byte wins over start byte when both are equal.
                priority if (rx == cfg.end_byte) begin
                    n_err   = 1'b1;
                    n_phase = PH_HUNT;
                end else if (rx == cfg.start_byte) begin
                    n_err   = 1'b1;
                    n_idx   = '0;
                    n_sum   = SUM_SEED;
                    n_zero  = 1'b0;
                    n_phase = PH_DEST;
                end else begin
                    n_pv   = 1'b1;
                    n_pb   = rx;
                    n_pi   = idx_ext[7:0];
                    n_zero = zero_now;
                    if (!zero_now) begin
                        n_sum = r_sum + rx;
                    end
                    if ((CMP_W'(idx_inc) >= CMP_W'(r_len)) ||
                        (CMP_W'(idx_inc) >= MSG_LIMIT)) begin
                        n_idx   = '0;
                        n_phase = PH_SUM;
                    end else begin
                        n_idx = idx_inc[IDX_W-1:0];
                    end
                end
            end
            PH_SUM: begin
                if (rx == r_sum) begin
                    n_phase = PH_END;
                end else begin
                    n_err   = 1'b1;
                    n_phase = PH_HUNT;
                end
            end
            PH_END: begin
                n_ok    = (rx == cfg.end_byte);
                n_err   = (rx != cfg.end_byte);
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // Parser state, result register and its occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_idx       <= '0;
            r_len       <= '0;
            r_sum       <= SUM_SEED;
            r_zero      <= 1'b0;
            r_src       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_pb        <= '0;
            r_pi        <= '0;
            r_ok        <= 1'b0;
            r_err       <= 1'b0;
        end else if (rx_fire) begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_len       <= n_len;
            r_sum       <= n_sum;
            r_zero      <= n_zero;
            r_src       <= n_src;
            r_cnt       <= n_cnt;
            r_out_valid <= 1'b1;
            r_pv        <= n_pv;
            r_pb        <= n_pb;
            r_pi        <= n_pi;
            r_ok        <= n_ok;
            r_err       <= n_err;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.payload_valid = r_pv;
    assign o_res.payload_byte  = r_pb;
    assign o_res.payload_index = r_pi;
    assign o_res.frame_ok      = r_ok;
    assign o_res.frame_error   = r_err;
    assign o_res.source_id     = r_src;
    assign o_res.msg_count     = r_cnt;

    // A result never reports both outcomes at once.
    a_ok_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_ok && r_err))
        else $error("frame_ok and frame_error both set");

    // A payload byte is never an error byte.
    a_pv_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pv) |-> !r_err)
        else $error("payload byte flagged as error");

    // The end byte check always returns to hunting.
    a_end_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_fire && r_phase == PH_END) |=> (r_phase == PH_HUNT))
        else $error("parser did not return to hunting after end check");

    // The payload index stays below the capacity.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_idx) < MSG_LIMIT)
        else $error("payload index reached capacity");

endmodule
